FILE: rtl/wus_pkg.sv
// shared constants, types and arithmetic helpers for the sub-pixel splat unit
package wus_pkg;

  localparam int MATRIX_COLS = 16;
  localparam int MATRIX_ROWS = 16;
  localparam int DEPTH       = MATRIX_COLS * MATRIX_ROWS;
  localparam int ADDR_W      = $clog2(DEPTH);

  localparam int POS_W   = 12;
  localparam int FRAC_W  = 8;
  localparam int INT_W   = POS_W - FRAC_W;
  localparam int COORD_W = 5;
  localparam int CH_W    = 8;
  localparam int NUM_PIX = 4;
  localparam int PIX_W   = $clog2(NUM_PIX);

  localparam logic [CH_W-1:0]  CH_MAX   = '1;
  localparam logic [PIX_W-1:0] PIX_LAST = PIX_W'(NUM_PIX - 1);

  typedef enum logic {
    CMD_SPLAT = 1'b0,
    CMD_SET   = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_WGT  = 5'b00010,
    S_RD   = 5'b00100,
    S_MOD  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  // (a*b + a + b) >> 8, never exceeds 16 bits
  function automatic logic [CH_W-1:0] pair_weight(input logic [CH_W-1:0] a,
                                                  input logic [CH_W-1:0] b);
    logic [2*CH_W-1:0] acc;
    acc = (2*CH_W)'(a) * (2*CH_W)'(b) + (2*CH_W)'(a) + (2*CH_W)'(b);
    return acc[2*CH_W-1:CH_W];
  endfunction

  // (c * w) >> 8 then saturating add onto the stored channel
  function automatic logic [CH_W-1:0] blend(input logic [CH_W-1:0] old,
                                            input logic [CH_W-1:0] c,
                                            input logic [CH_W-1:0] w);
    logic [2*CH_W-1:0] prod;
    logic [CH_W:0]     sum;
    prod = (2*CH_W)'(c) * (2*CH_W)'(w);
    sum  = {1'b0, old} + {1'b0, prod[2*CH_W-1:CH_W]};
    return sum[CH_W] ? CH_MAX : sum[CH_W-1:0];
  endfunction

endpackage

FILE: rtl/wu_subpixel_splat_unit.sv
// sub-pixel anti-aliased splat unit over a 16x16 rgb frame store
// A splat word updates the four pixels around a 4.8 position with bilinear weights and
// saturating adds; a set word overwrites one pixel. Results come out one per pixel, in
// order (x,y), (x+1,y), (x,y+1), (x+1,y+1), with last on the final one. Each pixel goes
// through a read, a modify/write and an output state on the single-port frame memory; a
// new word is taken only after the last result word of the previous one, and the output
// state holds while out_ready is low. Pixels past the edge are not touched and report
// in_range low with a black colour. Per-entry valid flops make the store read as black
// after reset, so no clearing pass is needed.
module wu_subpixel_splat_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_command,
  input  logic [wus_pkg::POS_W-1:0]   in_pos_x,
  input  logic [wus_pkg::POS_W-1:0]   in_pos_y,
  input  logic [wus_pkg::CH_W-1:0]    in_red,
  input  logic [wus_pkg::CH_W-1:0]    in_green,
  input  logic [wus_pkg::CH_W-1:0]    in_blue,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [wus_pkg::COORD_W-1:0] out_pix_col,
  output logic [wus_pkg::COORD_W-1:0] out_pix_row,
  output logic [wus_pkg::CH_W-1:0]    out_red,
  output logic [wus_pkg::CH_W-1:0]    out_green,
  output logic [wus_pkg::CH_W-1:0]    out_blue,
  output logic                        out_in_range,
  output logic                        out_last
);
  import wus_pkg::*;

  state_t             state_r, state_nxt;
  logic [PIX_W-1:0]   pix_r, pix_nxt;
  logic               out_valid_r, out_valid_nxt;

  cmd_t               cmd_r;
  logic [INT_W-1:0]   bx_r, by_r;
  logic [FRAC_W-1:0]  fx_r, fy_r;
  pixel_t             color_r;
  logic [CH_W-1:0]    w_r [NUM_PIX];

  pixel_t             mem [DEPTH];
  pixel_t             mem_q_r;
  logic [DEPTH-1:0]   vld_r;
  logic               rd_vld_r;

  logic [COORD_W-1:0] col_r, row_r;
  pixel_t             res_r;
  logic               res_ok_r, res_last_r;

  logic [COORD_W-1:0] xn, yn;
  logic               ok;
  logic [ADDR_W-1:0]  addr;
  logic               is_last;
  logic [CH_W-1:0]    w_sel;
  pixel_t             old_px, new_px;

  // current pixel position and address
  always_comb begin
    xn      = COORD_W'(bx_r) + COORD_W'(pix_r[0]);
    yn      = COORD_W'(by_r) + COORD_W'(pix_r[PIX_W-1]);
    ok      = (int'(xn) < MATRIX_COLS) && (int'(yn) < MATRIX_ROWS);
    addr    = ADDR_W'(int'(yn) * MATRIX_COLS + int'(xn));
    is_last = (cmd_r == CMD_SET) || (pix_r == PIX_LAST);
    w_sel   = w_r[pix_r];
    old_px  = rd_vld_r ? mem_q_r : '0;
    if (cmd_r == CMD_SET) begin
      new_px = color_r;
    end else begin
      new_px.red   = blend(old_px.red,   color_r.red,   w_sel);
      new_px.green = blend(old_px.green, color_r.green, w_sel);
      new_px.blue  = blend(old_px.blue,  color_r.blue,  w_sel);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    pix_nxt       = pix_r;
    out_valid_nxt = out_valid_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_WGT;
          pix_nxt   = '0;
        end
      end
      S_WGT: state_nxt = S_RD;
      S_RD:  state_nxt = S_MOD;
      S_MOD: begin
        state_nxt     = S_OUT;
        out_valid_nxt = 1'b1;
      end
      S_OUT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (res_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_RD;
            pix_nxt   = pix_r + PIX_W'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pix_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pix_r       <= pix_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // word capture and weights
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      cmd_r   <= cmd_t'(in_command);
      bx_r    <= in_pos_x[POS_W-1:FRAC_W];
      by_r    <= in_pos_y[POS_W-1:FRAC_W];
      fx_r    <= in_pos_x[FRAC_W-1:0];
      fy_r    <= in_pos_y[FRAC_W-1:0];
      color_r <= '{red: in_red, green: in_green, blue: in_blue};
    end
    if (state_r == S_WGT) begin
      w_r[0] <= pair_weight(~fx_r, ~fy_r);
      w_r[1] <= pair_weight(fx_r,  ~fy_r);
      w_r[2] <= pair_weight(~fx_r, fy_r);
      w_r[3] <= pair_weight(fx_r,  fy_r);
    end
  end

  // frame memory, read in S_RD, written in S_MOD
  always_ff @(posedge clk) begin
    if (state_r == S_RD && ok) begin
      mem_q_r <= mem[addr];
    end
    if (state_r == S_MOD && ok) begin
      mem[addr] <= new_px;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (state_r == S_RD) begin
        rd_vld_r <= vld_r[addr];
      end
      if (state_r == S_MOD && ok) begin
        vld_r[addr] <= 1'b1;
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (state_r == S_MOD) begin
      col_r      <= xn;
      row_r      <= yn;
      res_r      <= ok ? new_px : '0;
      res_ok_r   <= ok;
      res_last_r <= is_last;
    end
  end

  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_pix_col  = col_r;
  assign out_pix_row  = row_r;
  assign out_red      = res_r.red;
  assign out_green    = res_r.green;
  assign out_blue     = res_r.blue;
  assign out_in_range = res_ok_r;
  assign out_last     = res_last_r;

`ifndef NO_ASSERTIONS
  a_out_in_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_OUT)
    else $error("result word valid outside output state");

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid_r)
    else $error("input ready while a result word is pending");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ready && res_last_r) |=> state_r == S_IDLE)
    else $error("no return to idle after final result word");

  a_edge_is_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_ok_r) |-> res_r == '0)
    else $error("out of range result word carries a colour");
`endif

endmodule

FILE: verif/splat_checker.sv
// scoreboard with its own frame store copy and pixel predictor for the splat unit
`timescale 1ns / 100ps
module splat_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic                        in_command,
  input  logic [wus_pkg::POS_W-1:0]   in_pos_x,
  input  logic [wus_pkg::POS_W-1:0]   in_pos_y,
  input  logic [wus_pkg::CH_W-1:0]    in_red,
  input  logic [wus_pkg::CH_W-1:0]    in_green,
  input  logic [wus_pkg::CH_W-1:0]    in_blue,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [wus_pkg::COORD_W-1:0] out_pix_col,
  input  logic [wus_pkg::COORD_W-1:0] out_pix_row,
  input  logic [wus_pkg::CH_W-1:0]    out_red,
  input  logic [wus_pkg::CH_W-1:0]    out_green,
  input  logic [wus_pkg::CH_W-1:0]    out_blue,
  input  logic                        out_in_range,
  input  logic                        out_last,
  output int                          fail_count,
  output int                          words_pending
);
  import wus_pkg::*;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    pixel_t             color;
    logic               in_range;
    logic               last;
  } pix_result_t;

  pixel_t      frame_copy [DEPTH];
  pix_result_t pixel_results_q [$];
  int          err_cnt = 0;

  // bilinear coverage: ((a+1)*(b+1)-1) >> 8
  function automatic logic [CH_W-1:0] coverage_weight(input logic [CH_W-1:0] a,
                                                      input logic [CH_W-1:0] b);
    int t;
    t = (int'(a) + 1) * (int'(b) + 1) - 1;
    return CH_W'(t >> CH_W);
  endfunction

  function automatic logic [CH_W-1:0] add_share(input logic [CH_W-1:0] old,
                                                input logic [CH_W-1:0] c,
                                                input logic [CH_W-1:0] w);
    int s;
    s = int'(old) + ((int'(c) * int'(w)) >> CH_W);
    return (s > int'(CH_MAX)) ? CH_MAX : CH_W'(s);
  endfunction

  task automatic predict_pixels(input cmd_t cmd, input logic [POS_W-1:0] px,
                                input logic [POS_W-1:0] py, input pixel_t color);
    logic [COORD_W-1:0] base_x;
    logic [COORD_W-1:0] base_y;
    logic [FRAC_W-1:0]  fx;
    logic [FRAC_W-1:0]  fy;
    logic [CH_W-1:0]    wt [NUM_PIX];
    logic [COORD_W-1:0] xn;
    logic [COORD_W-1:0] yn;
    logic               ok;
    int                 idx;
    pixel_t             nv;
    base_x = COORD_W'(px[POS_W-1:FRAC_W]);
    base_y = COORD_W'(py[POS_W-1:FRAC_W]);
    fx = px[FRAC_W-1:0];
    fy = py[FRAC_W-1:0];
    if (cmd == CMD_SET) begin
      ok = (base_x < MATRIX_COLS) && (base_y < MATRIX_ROWS);
      if (ok) begin
        idx = int'(base_y) * MATRIX_COLS + int'(base_x);
        frame_copy[idx] = color;
      end
      pixel_results_q.push_back({base_x, base_y, ok ? color : pixel_t'('0), ok, 1'b1});
    end else begin
      wt[0] = coverage_weight(~fx, ~fy);
      wt[1] = coverage_weight(fx, ~fy);
      wt[2] = coverage_weight(~fx, fy);
      wt[3] = coverage_weight(fx, fy);
      for (int i = 0; i < NUM_PIX; i++) begin
        xn = base_x + COORD_W'(i % 2);
        yn = base_y + COORD_W'(i / 2);
        ok = (xn < MATRIX_COLS) && (yn < MATRIX_ROWS);
        nv = '0;
        if (ok) begin
          idx = int'(yn) * MATRIX_COLS + int'(xn);
          nv.red   = add_share(frame_copy[idx].red, color.red, wt[i]);
          nv.green = add_share(frame_copy[idx].green, color.green, wt[i]);
          nv.blue  = add_share(frame_copy[idx].blue, color.blue, wt[i]);
          frame_copy[idx] = nv;
        end
        pixel_results_q.push_back({xn, yn, nv, ok, 1'(i == NUM_PIX - 1)});
      end
    end
  endtask

  task automatic check_field(input string name, input logic [CH_W-1:0] exp_v,
                             input logic [CH_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  task automatic check_pixel_word();
    pix_result_t e;
    if (pixel_results_q.size() == 0) begin
      $error("pixel word col %0d row %0d with nothing pending", out_pix_col, out_pix_row);
      err_cnt++;
    end else begin
      e = pixel_results_q.pop_front();
      check_field("pix_col", CH_W'(e.col), CH_W'(out_pix_col));
      check_field("pix_row", CH_W'(e.row), CH_W'(out_pix_row));
      check_field("out_red", e.color.red, out_red);
      check_field("out_green", e.color.green, out_green);
      check_field("out_blue", e.color.blue, out_blue);
      check_field("in_range", CH_W'(e.in_range), CH_W'(out_in_range));
      check_field("last", CH_W'(e.last), CH_W'(out_last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (frame_copy[i]) frame_copy[i] = '0;
      pixel_results_q.delete();
    end else begin
      if (out_valid && out_ready) check_pixel_word();
      if (in_valid && in_ready)
        predict_pixels(cmd_t'(in_command), in_pos_x, in_pos_y, {in_red, in_green, in_blue});
    end
    fail_count    <= err_cnt;
    words_pending <= pixel_results_q.size();
  end

endmodule

FILE: verif/testbench.sv
// top of the splat unit testbench: clock, reset, stimulus, receiver stalls and verdict
`timescale 1ns / 100ps
module testbench;
  import wus_pkg::*;

  localparam int RANDOM_WORDS = 250;
  localparam int LONG_HOLD    = 400;
  localparam int CYCLE_LIMIT  = 200000;

  typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_BEAT} rx_mode_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_command;
  logic [POS_W-1:0]   in_pos_x;
  logic [POS_W-1:0]   in_pos_y;
  logic [CH_W-1:0]    in_red;
  logic [CH_W-1:0]    in_green;
  logic [CH_W-1:0]    in_blue;
  logic               out_valid;
  logic               out_ready;
  logic [COORD_W-1:0] out_pix_col;
  logic [COORD_W-1:0] out_pix_row;
  logic [CH_W-1:0]    out_red;
  logic [CH_W-1:0]    out_green;
  logic [CH_W-1:0]    out_blue;
  logic               out_in_range;
  logic               out_last;
  int                 fail_count;
  int                 words_pending;

  int       cycle_count = 0;
  bit       hold_req = 1'b0;
  bit       hold_done = 1'b0;
  rx_mode_t rx_mode;
  int       rx_stretch;
  int       sent;
  int       burst;

  wu_subpixel_splat_unit DUT (.*);
  splat_checker CHK (.*);

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("testbench: errors");
    $finish;
  end

  task automatic offer_word(input cmd_t cmd, input logic [POS_W-1:0] x,
                            input logic [POS_W-1:0] y, input logic [CH_W-1:0] r,
                            input logic [CH_W-1:0] g, input logic [CH_W-1:0] b);
    @(negedge clk);
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_pos_x   <= x;
    in_pos_y   <= y;
    in_red     <= r;
    in_green   <= g;
    in_blue    <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (words_pending == 0);
    @(negedge clk);
  endtask

  function automatic logic [POS_W-1:0] pick_pos();
    case ($urandom_range(0, 3))
      0:       return POS_W'($urandom);
      1:       return {INT_W'($urandom_range(0, 1)), FRAC_W'($urandom)};
      2:       return {INT_W'($urandom_range(14, 15)), FRAC_W'($urandom)};
      default: return {INT_W'($urandom_range(6, 7)), FRAC_W'($urandom)};
    endcase
  endfunction

  function automatic logic [CH_W-1:0] pick_channel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CH_MAX;
      default: return CH_W'($urandom);
    endcase
  endfunction

  // receiver: stretches of different stall patterns, one long hold on request
  initial begin
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      rx_mode    = rx_mode_t'($urandom_range(0, 3));
      rx_stretch = $urandom_range(10, 60);
      for (int k = 0; k < rx_stretch; k++) begin
        @(negedge clk);
        if (hold_req && !hold_done) begin
          out_ready <= 1'b0;
          repeat (LONG_HOLD - 1) @(negedge clk);
          hold_done = 1'b1;
        end else begin
          case (rx_mode)
            RX_OPEN:  out_ready <= 1'b1;
            RX_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY: out_ready <= ($urandom_range(0, 3) == 0);
            default:  out_ready <= ((k % 3) != 2);
          endcase
        end
      end
    end
  end

  initial begin
    in_valid   = 1'b0;
    in_command = CMD_SPLAT;
    in_pos_x   = '0;
    in_pos_y   = '0;
    in_red     = '0;
    in_green   = '0;
    in_blue    = '0;
    rst_n      = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed words
    offer_word(CMD_SPLAT, 12'h000, 12'h000, 8'h00, 8'h00, 8'h00);
    offer_word(CMD_SET,   12'h000, 12'h000, 8'hff, 8'hff, 8'hff);
    offer_word(CMD_SPLAT, 12'h000, 12'h000, 8'hff, 8'hff, 8'hff);
    offer_word(CMD_SPLAT, 12'hfff, 12'hfff, 8'hff, 8'hff, 8'hff);
    offer_word(CMD_SPLAT, 12'hf00, 12'hf00, 8'hff, 8'h80, 8'h01);
    offer_word(CMD_SPLAT, 12'hf80, 12'h340, 8'h80, 8'h40, 8'h20);
    offer_word(CMD_SPLAT, 12'h2a0, 12'hfc0, 8'h11, 8'h99, 8'hee);
    offer_word(CMD_SET,   12'hfff, 12'hfff, 8'h01, 8'h02, 8'h04);
    offer_word(CMD_SPLAT, 12'hfff, 12'hfff, 8'hff, 8'hff, 8'hff);
    offer_word(CMD_SPLAT, 12'h0ff, 12'h1ff, 8'haa, 8'h55, 8'hff);
    offer_word(CMD_SPLAT, 12'h080, 12'h080, 8'h80, 8'h80, 8'h80);
    offer_word(CMD_SPLAT, 12'h5a3, 12'h7c1, 8'hc8, 8'hc8, 8'hc8);
    offer_word(CMD_SPLAT, 12'h5a3, 12'h7c1, 8'hc8, 8'hc8, 8'hc8);
    offer_word(CMD_SPLAT, 12'h5a3, 12'h7c1, 8'hc8, 8'hc8, 8'hc8);
    offer_word(CMD_SPLAT, 12'h5a3, 12'h7c1, 8'hff, 8'h00, 8'h7f);
    offer_word(CMD_SET,   12'h3c7, 12'h8e1, 8'h5a, 8'ha5, 8'h3c);
    offer_word(CMD_SPLAT, 12'h301, 12'h8fe, 8'h00, 8'h00, 8'h00);
    offer_word(CMD_SET,   12'h555, 12'haaa, 8'h00, 8'h00, 8'h00);
    offer_word(CMD_SPLAT, 12'haaa, 12'h555, 8'h55, 8'haa, 8'h55);
    offer_word(CMD_SET,   12'hf00, 12'h0ff, 8'hfe, 8'h7f, 8'h80);
    idle_cycles(5);

    sent = 0;
    while (sent < RANDOM_WORDS) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        if (sent == 60) hold_req = 1'b1;
        if (sent == 160) drain_results();
        offer_word(cmd_t'(($urandom_range(0, 9) < 7) ? CMD_SPLAT : CMD_SET),
                   pick_pos(), pick_pos(),
                   pick_channel(), pick_channel(), pick_channel());
        sent++;
      end
      idle_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15));
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
